FILE: rtl/lcs_pkg.sv
// Shared types for the LCS engine.
// No dependencies; used by front, queue and back.
`default_nettype none
package lcs_pkg;
  localparam int LEN_W = 7;   // sequence length, 0..64
  localparam int IDX_W = 6;   // symbol slot within a sequence
  localparam int SYM_W = 8;

  // Queue word from the front: optional symbol store, optional run request
  typedef struct packed {
    logic             sel;       // 0 first sequence, 1 second
    logic             wr;        // store sym at addr
    logic [IDX_W-1:0] addr;
    logic [SYM_W-1:0] sym;
    logic             pair_end;  // pair closed, run the table
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] m_len;
    logic             ovf;
  } cmd_t;
endpackage
`default_nettype wire

FILE: rtl/lcs_fifo.sv
// Two-word queue between the LCS front and back.
// Depends on lcs_pkg.
`default_nettype none
module lcs_fifo (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  lcs_pkg::cmd_t  push_word,
  output logic           full,
  input  wire            pop,
  output logic           nonempty,
  output lcs_pkg::cmd_t  head
);
  import lcs_pkg::*;

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full     = (cnt == 2'd2);
  assign nonempty = (cnt != 2'd0);
  assign head     = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/lcs_front.sv
// LCS front: takes input words, tracks lengths, close flags and overflow.
// Depends on lcs_pkg; feeds lcs_fifo.
`default_nettype none
module lcs_front #(
  parameter int MAX_LEN = 64
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            accept,
  input  wire            opcode,
  input  wire            has_symbol,
  input  wire [7:0]      symbol,
  input  wire            last,
  output logic           push,
  output lcs_pkg::cmd_t  push_word
);
  import lcs_pkg::*;

  logic [1:0]       ended, ended_next, bitm;
  logic [LEN_W-1:0] len_a, len_b, cur_len;
  logic             ovf, ovf_next, closed, wr;

  always_comb begin
    bitm       = opcode ? 2'b10 : 2'b01;
    closed     = |(ended & bitm);
    cur_len    = opcode ? len_b : len_a;
    wr         = has_symbol && (cur_len < LEN_W'(MAX_LEN));
    ovf_next   = ovf | (has_symbol && !wr);
    ended_next = ended | (last ? bitm : 2'b00);
    push_word.sel      = opcode;
    push_word.wr       = wr;
    push_word.addr     = cur_len[IDX_W-1:0];
    push_word.sym      = symbol;
    push_word.pair_end = (ended_next == 2'b11);
    push_word.n_len    = len_a + LEN_W'(wr && !opcode);
    push_word.m_len    = len_b + LEN_W'(wr && opcode);
    push_word.ovf      = ovf_next;
    push = accept && !closed && (wr || push_word.pair_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ended <= 2'b00;
      len_a <= '0;
      len_b <= '0;
      ovf   <= 1'b0;
    end else if (accept && !closed) begin
      if (push_word.pair_end) begin
        ended <= 2'b00;
        len_a <= '0;
        len_b <= '0;
        ovf   <= 1'b0;
      end else begin
        ended <= ended_next;
        len_a <= push_word.n_len;
        len_b <= push_word.m_len;
        ovf   <= ovf_next;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/lcs_back.sv
// LCS back: sequence stores, score table fill, traceback and result emit.
// Depends on lcs_pkg; drains lcs_fifo.
`default_nettype none
module lcs_back #(
  parameter int MAX_LEN = 64
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            q_nonempty,
  input  lcs_pkg::cmd_t  q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  wire            out_ready,
  output logic [7:0]     out_symbol,
  output logic [5:0]     position,
  output logic [6:0]     lcs_length,
  output logic           is_empty,
  output logic           overflow,
  output logic           run_end
);
  import lcs_pkg::*;

  localparam int W   = MAX_LEN + 1;
  localparam int TAW = $clog2(W * W);
  localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_FRD = 4'd1, S_FWR = 4'd2, S_LRD = 4'd3,
                         S_LWT = 4'd4, S_TRD = 4'd5, S_TEV = 4'd6, S_ERD = 4'd7,
                         S_EWT = 4'd8;

  logic [SYM_W-1:0] seq_a [MAX_LEN];
  logic [SYM_W-1:0] seq_b [MAX_LEN];
  logic [SYM_W-1:0] rbuf  [MAX_LEN];
  logic [LEN_W-1:0] tbl   [W*W];

  logic [3:0]       st;
  logic [LEN_W-1:0] i, j, n, m, idx, len, k, left, diag;
  logic             ovf;
  logic [SYM_W-1:0] a_q, b_q, r_q;
  logic [LEN_W-1:0] t0_q, t1_q;
  logic [IW-1:0]    a_ad, b_ad;
  logic [TAW-1:0]   t0_ad, t1_ad, tw_ad;
  logic [LEN_W-1:0] up, lf, val, i1, j1;
  logic             match, out_free;

  function automatic logic [TAW-1:0] tad(input logic [LEN_W-1:0] r, input logic [LEN_W-1:0] c);
    tad = TAW'(r) * TAW'(W) + TAW'(c);
  endfunction

  assign q_pop    = (st == S_IDLE) && q_nonempty;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    i1    = i - LEN_W'(1);
    j1    = j - LEN_W'(1);
    a_ad  = i1[IW-1:0];
    b_ad  = j1[IW-1:0];
    t0_ad = (st == S_LRD) ? tad(n, m) : tad(i1, j);
    t1_ad = tad(i, j1);
    tw_ad = tad(i, j);
    match = (a_q == b_q);
    up    = (i == LEN_W'(1)) ? '0 : t0_q;
    lf    = (j == LEN_W'(1)) ? '0 : t1_q;
    val   = match ? diag + LEN_W'(1) : ((up > left) ? up : left);
  end

  // Memories
  always_ff @(posedge clk) begin
    if (q_pop && q_head.wr && !q_head.sel) seq_a[q_head.addr[IW-1:0]] <= q_head.sym;
    if (q_pop && q_head.wr && q_head.sel) seq_b[q_head.addr[IW-1:0]] <= q_head.sym;
    a_q <= seq_a[a_ad];
    b_q <= seq_b[b_ad];
  end
  always_ff @(posedge clk) begin
    if (st == S_FWR) tbl[tw_ad] <= val;
    t0_q <= tbl[t0_ad];
    t1_q <= tbl[t1_ad];
  end
  always_ff @(posedge clk) begin
    if (st == S_TEV && match && idx != '0) rbuf[idx[IW-1:0] - IW'(1)] <= a_q;
    r_q <= rbuf[k[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && st != S_EWT) out_valid <= 1'b0;
      case (st)
        S_IDLE: if (q_pop && q_head.pair_end) begin
          n    <= q_head.n_len;
          m    <= q_head.m_len;
          ovf  <= q_head.ovf;
          i    <= LEN_W'(1);
          j    <= LEN_W'(1);
          left <= '0;
          diag <= '0;
          k    <= '0;
          len  <= '0;
          st   <= (q_head.n_len == '0 || q_head.m_len == '0) ? S_EWT : S_FRD;
        end
        S_FRD: st <= S_FWR;
        S_FWR: begin
          if (j == m) begin
            j    <= LEN_W'(1);
            left <= '0;
            diag <= '0;
            if (i == n) begin
              st <= S_LRD;
            end else begin
              i  <= i + LEN_W'(1);
              st <= S_FRD;
            end
          end else begin
            j    <= j + LEN_W'(1);
            diag <= up;
            left <= val;
            st   <= S_FRD;
          end
        end
        S_LRD: st <= S_LWT;
        S_LWT: begin
          len <= t0_q;
          idx <= t0_q;
          i   <= n;
          j   <= m;
          st  <= S_TRD;
        end
        S_TRD: st <= (i == '0 || j == '0) ? S_ERD : S_TEV;
        S_TEV: begin
          st <= S_TRD;
          if (match) begin
            if (idx != '0) idx <= idx - LEN_W'(1);
            i <= i1;
            j <= j1;
          end else if (up > lf) begin
            i <= i1;
          end else begin
            j <= j1;
          end
        end
        S_ERD: st <= S_EWT;
        S_EWT: if (out_free) begin
          out_valid  <= 1'b1;
          overflow   <= ovf;
          lcs_length <= len;
          position   <= k[5:0];
          is_empty   <= (len == '0);
          out_symbol <= (len == '0) ? 8'd0 : r_q;
          run_end    <= (len == '0) || (k == len - LEN_W'(1));
          if (len == '0 || k == len - LEN_W'(1)) begin
            st <= S_IDLE;
          end else begin
            k  <= k + LEN_W'(1);
            st <= S_ERD;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) q_pop |-> st == S_IDLE)
    else $error("queue popped while busy");
  a_idx_ok: assert property (@(posedge clk) disable iff (rst) (st == S_TEV && match) |-> idx != '0)
    else $error("traceback index underflow");
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (st == S_FRD || st == S_FWR) |-> (i <= n && j <= m && i != '0 && j != '0))
    else $error("fill index out of range");
  a_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_empty) |-> (7'(position) < lcs_length))
    else $error("position beyond length");
`endif
endmodule
`default_nettype wire

FILE: rtl/longest_common_subsequence_top.sv
// Top level of the LCS engine: front, two-word queue, back.
// Depends on lcs_pkg, lcs_front, lcs_fifo, lcs_back.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | opcode, has_symbol, symbol, last
//  out     | out_valid / out_ready| out_symbol, position, lcs_length, is_empty, overflow, run_end
//
// Input words are taken one per cycle while the queue has room; the back pops
// load words only while idle. Solving a pair of lengths n, m runs the table fill
// (one score table access pair per cell), then traceback, then one result word at a
// time: the read-then-write of each score cell sets the pace of the fill.
// Reset is synchronous and clears flags, lengths and control; stores are not cleared.
// A stalled output holds the back; the front keeps filling the queue meanwhile.
`default_nettype none
module longest_common_subsequence_top #(
  parameter int MAX_LEN = 64
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        opcode,
  input  wire        has_symbol,
  input  wire [7:0]  symbol,
  input  wire        last,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_symbol,
  output logic [5:0] position,
  output logic [6:0] lcs_length,
  output logic       is_empty,
  output logic       overflow,
  output logic       run_end
);
  import lcs_pkg::*;

  cmd_t push_word, head;
  logic push, full, pop, nonempty;

  // The queue refuses words only when full; dropped words never push.
  assign in_ready = !full;

  lcs_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk(clk), .rst(rst), .accept(in_valid && in_ready),
    .opcode(opcode), .has_symbol(has_symbol), .symbol(symbol), .last(last),
    .push(push), .push_word(push_word)
  );

  lcs_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_word(push_word), .full(full),
    .pop(pop), .nonempty(nonempty), .head(head)
  );

  lcs_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk(clk), .rst(rst), .q_nonempty(nonempty), .q_head(head), .q_pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_symbol(out_symbol),
    .position(position), .lcs_length(lcs_length), .is_empty(is_empty),
    .overflow(overflow), .run_end(run_end)
  );
endmodule
`default_nettype wire
